// ===== rtl/core/kvi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kvi_pkg: shared types and constants for the keyframe vector interpolator
// Key storage layout, status and action codes, divider interface.
// ----------------------------------------------------------------------------
package kvi_pkg;

  localparam int KEYS_DEF = 64;
  localparam int TIME_W   = 32;
  localparam int VAL_W    = 32;
  localparam int FRAC_W   = 16;
  localparam int KCNT_W   = 7;
  localparam int SEG_W    = 6;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_INTERP = 2'd1;
  localparam logic [1:0] ST_CLAMP  = 2'd2;
  localparam logic [1:0] ST_BAD    = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] tm;
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
    logic [VAL_W-1:0]  z;
  } key_ent_t;

  typedef struct packed {
    logic              go;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/keyframe_vector_interpolator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_vector_interpolator: linear keyframe interpolation of an xyz track
// Stores up to KEYS keys (time, x, y, z) and answers time queries with the
// interpolated vector.
// Usage:
//   An item is taken when start is high and busy is low. in_action selects a
//   key load (in_key_index, in_key_time, in_key_x/y/z) or a query
//   (in_query_time). cfg_we writes cfg_wdata to the key count register.
//   Every item gives one result, shown for one cycle with out_valid.
//   A load's result appears the cycle after acceptance, and a new item may be
//   given in that same cycle.
//   A query scans key times one per cycle from the key memory. A clamped
//   query, or one on a single key, ends with the scan or with a start-key read
//   and check; an interpolating query goes on to wait for the serial divider
//   and then to the shared multiplier, which forms x, y and z in turn, before
//   its result. busy falls with the result, so the next item may be given in
//   the cycle that shows it.
//   Reset sets the key count to 1; key memory contents are undefined until
//   loaded. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module keyframe_vector_interpolator #(
  parameter int KEYS = kvi_pkg::KEYS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_action,
  input  wire logic [kvi_pkg::SEG_W-1:0]  in_key_index,
  input  wire logic [kvi_pkg::TIME_W-1:0] in_key_time,
  input  wire logic signed [kvi_pkg::VAL_W-1:0] in_key_x,
  input  wire logic signed [kvi_pkg::VAL_W-1:0] in_key_y,
  input  wire logic signed [kvi_pkg::VAL_W-1:0] in_key_z,
  input  wire logic [kvi_pkg::TIME_W-1:0] in_query_time,
  input  wire logic                       cfg_we,
  input  wire logic [kvi_pkg::KCNT_W-1:0] cfg_wdata,
  output logic                            out_valid,
  output logic signed [kvi_pkg::VAL_W-1:0] out_x,
  output logic signed [kvi_pkg::VAL_W-1:0] out_y,
  output logic signed [kvi_pkg::VAL_W-1:0] out_z,
  output logic [1:0]                      out_status,
  output logic [kvi_pkg::SEG_W-1:0]       out_segment
);
  import kvi_pkg::*;

  localparam int IDX_W = $clog2(KEYS);
  localparam int PROD_W = FRAC_W + VAL_W + 2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_FETCH = 6'b000100,
    S_CHECK = 6'b001000,
    S_DIV   = 6'b010000,
    S_MUL   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  key_ent_t key_mem [KEYS];
  key_ent_t rdata_r;
  key_ent_t wdata;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             mem_we;

  logic [KCNT_W-1:0] key_count_r;
  logic [31:0]       kc32, n0, nc;
  logic [IDX_W-1:0]  n_last;
  logic              n_single;
  logic              idx_bad;

  logic [TIME_W-1:0] q_r, q_nxt;
  logic [IDX_W-1:0]  last_r, last_nxt;
  logic              single_r, single_nxt;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic [IDX_W-1:0]  chk_r, chk_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]  seg_r, seg_nxt;
  key_ent_t          end_r, end_nxt;
  key_ent_t          start_r, start_nxt;
  logic signed [VAL_W:0] dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [1:0]        mcnt_r, mcnt_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [VAL_W-1:0]  res_x_r, res_x_nxt, res_y_r, res_y_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_x_r, out_x_nxt, out_y_r, out_y_nxt, out_z_r, out_z_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [SEG_W-1:0]  out_seg_r, out_seg_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [FRAC_W:0] fac;
  logic signed [VAL_W:0]  dsel;
  logic [VAL_W-1:0]       ssel;
  logic [VAL_W-1:0]       sum;

  kvi_frac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign kc32     = {{(32-KCNT_W){1'b0}}, key_count_r};
  assign n0       = (kc32 == 32'd0) ? 32'd1 : kc32;
  assign nc       = (n0 > 32'(KEYS)) ? 32'(KEYS) : n0;
  assign n_last   = IDX_W'(nc - 32'd1);
  assign n_single = (nc == 32'd1);
  assign idx_bad  = {{(32-SEG_W){1'b0}}, in_key_index} >= 32'(KEYS);
  assign wr_addr  = IDX_W'(in_key_index);
  assign wdata    = '{tm: in_key_time, x: in_key_x, y: in_key_y, z: in_key_z};

  assign fac = $signed({1'b0, div_rsp.quo});

  always_comb begin
    case (mcnt_r)
      2'd0:    dsel = dx_r;
      2'd1:    dsel = dy_r;
      default: dsel = dz_r;
    endcase
    case (mcnt_r)
      2'd1:    ssel = start_r.x;
      2'd2:    ssel = start_r.y;
      default: ssel = start_r.z;
    endcase
  end

  assign sum = ssel + prod_r[FRAC_W+VAL_W-1:FRAC_W];

  always_comb begin
    state_nxt      = state_r;
    q_nxt          = q_r;
    last_nxt       = last_r;
    single_nxt     = single_r;
    scan_nxt       = scan_r;
    chk_nxt        = chk_r;
    chk_v_nxt      = chk_v_r;
    seg_nxt        = seg_r;
    end_nxt        = end_r;
    start_nxt      = start_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    dz_nxt         = dz_r;
    mcnt_nxt       = mcnt_r;
    prod_nxt       = prod_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    out_valid_nxt  = 1'b0;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_z_nxt      = out_z_r;
    out_status_nxt = out_status_r;
    out_seg_nxt    = out_seg_r;
    rd_addr        = scan_r;
    mem_we         = 1'b0;
    div_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_action == ACT_LOAD) begin
            out_valid_nxt = 1'b1;
            out_x_nxt     = '0;
            out_y_nxt     = '0;
            out_z_nxt     = '0;
            out_seg_nxt   = '0;
            if (idx_bad) begin
              out_status_nxt = ST_BAD;
            end else begin
              out_status_nxt = ST_LOAD;
              mem_we         = 1'b1;
            end
          end else begin
            q_nxt      = in_query_time;
            last_nxt   = n_last;
            single_nxt = n_single;
            scan_nxt   = IDX_W'(1);
            chk_v_nxt  = 1'b0;
            seg_nxt    = '0;
            state_nxt  = n_single ? S_FETCH : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr   = scan_r;
        chk_nxt   = scan_r;
        chk_v_nxt = 1'b1;
        if (scan_r != last_r) begin
          scan_nxt = scan_r + 1'b1;
        end
        if (chk_v_r) begin
          if (q_r < rdata_r.tm) begin
            end_nxt   = rdata_r;
            seg_nxt   = IDX_W'(chk_r - 1'b1);
            state_nxt = S_FETCH;
          end else if (chk_r == last_r) begin
            out_valid_nxt  = 1'b1;
            out_x_nxt      = rdata_r.x;
            out_y_nxt      = rdata_r.y;
            out_z_nxt      = rdata_r.z;
            out_status_nxt = ST_CLAMP;
            out_seg_nxt    = SEG_W'(chk_r);
            state_nxt      = S_IDLE;
          end
        end
      end
      S_FETCH: begin
        rd_addr   = seg_r;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (single_r || (q_r < rdata_r.tm)) begin
          out_valid_nxt  = 1'b1;
          out_x_nxt      = rdata_r.x;
          out_y_nxt      = rdata_r.y;
          out_z_nxt      = rdata_r.z;
          out_status_nxt = single_r ? ST_INTERP : ST_CLAMP;
          out_seg_nxt    = SEG_W'(seg_r);
          state_nxt      = S_IDLE;
        end else begin
          start_nxt   = rdata_r;
          dx_nxt      = $signed({end_r.x[VAL_W-1], end_r.x} - {rdata_r.x[VAL_W-1], rdata_r.x});
          dy_nxt      = $signed({end_r.y[VAL_W-1], end_r.y} - {rdata_r.y[VAL_W-1], rdata_r.y});
          dz_nxt      = $signed({end_r.z[VAL_W-1], end_r.z} - {rdata_r.z[VAL_W-1], rdata_r.z});
          div_req.go  = 1'b1;
          div_req.num = q_r - rdata_r.tm;
          div_req.den = end_r.tm - rdata_r.tm;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          mcnt_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt = fac * dsel;
        mcnt_nxt = mcnt_r + 1'b1;
        case (mcnt_r)
          2'd1: res_x_nxt = sum;
          2'd2: res_y_nxt = sum;
          2'd3: begin
            out_valid_nxt  = 1'b1;
            out_x_nxt      = res_x_r;
            out_y_nxt      = res_y_r;
            out_z_nxt      = sum;
            out_status_nxt = ST_INTERP;
            out_seg_nxt    = SEG_W'(seg_r);
            state_nxt      = S_IDLE;
          end
          default: ;
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_addr] <= wdata;
    end
    rdata_r <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
      key_count_r <= KCNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chk_v_r     <= chk_v_nxt;
      if (cfg_we) begin
        key_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r          <= q_nxt;
    last_r       <= last_nxt;
    single_r     <= single_nxt;
    scan_r       <= scan_nxt;
    chk_r        <= chk_nxt;
    seg_r        <= seg_nxt;
    end_r        <= end_nxt;
    start_r      <= start_nxt;
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    dz_r         <= dz_nxt;
    mcnt_r       <= mcnt_nxt;
    prod_r       <= prod_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_z_r      <= out_z_nxt;
    out_status_r <= out_status_nxt;
    out_seg_r    <= out_seg_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_x       = $signed(out_x_r);
  assign out_y       = $signed(out_y_r);
  assign out_z       = $signed(out_z_r);
  assign out_status  = out_status_r;
  assign out_segment = out_seg_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_LOAD)) |=>
      (out_valid && ((out_status == ST_LOAD) || (out_status == ST_BAD))))
    else $error("load item without its result");

  a_interp_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_INTERP)) |->
      (($past(state_r) == S_CHECK) || ($past(state_r) == S_MUL)))
    else $error("interpolated result from an unexpected state");

endmodule

`default_nettype wire

// ===== rtl/core/kvi_frac_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kvi_frac_div: serial fraction divider
// Computes floor((num << FRAC_W) / den) for num < den, one quotient bit per
// cycle by restoring division. done is registered together with the last bit.
// ----------------------------------------------------------------------------
module kvi_frac_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kvi_pkg::div_req_t req,
  output kvi_pkg::div_rsp_t      rsp
);
  import kvi_pkg::*;

  localparam int CNT_W = $clog2(FRAC_W);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] den_r, den_nxt;
  logic [FRAC_W-1:0] quo_r, quo_nxt;
  logic [TIME_W:0]   rem2;
  logic              ge;

  assign rem2 = {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, den_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = req.num;
      den_nxt = req.den;
    end else if (run_r) begin
      rem_nxt = ge ? TIME_W'(rem2 - {1'b0, den_r}) : rem2[TIME_W-1:0];
      quo_nxt = {quo_r[FRAC_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(FRAC_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

// ===== verif/kvi_track_checker.sv =====
// ----------------------------------------------------------------------------
// kvi_track_checker: result predictor and scoreboard for the keyframe
// vector interpolator
// Watches the item and result channels and the key count register. It keeps
// its own copy of the key track and works out the vector, status and segment
// that every accepted item should give. Each result is compared field by
// field with the oldest prediction. The failure count and the number of
// predictions still waiting go to the testbench top.
// ----------------------------------------------------------------------------
module kvi_track_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_action,
  input  logic [5:0]  in_key_index,
  input  logic [31:0] in_key_time,
  input  logic [31:0] in_key_x,
  input  logic [31:0] in_key_y,
  input  logic [31:0] in_key_z,
  input  logic [31:0] in_query_time,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        out_valid,
  input  logic [31:0] out_x,
  input  logic [31:0] out_y,
  input  logic [31:0] out_z,
  input  logic [1:0]  out_status,
  input  logic [5:0]  out_segment,
  output int          mismatches,
  output int          outstanding
);
  import kvi_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  status;
    logic [5:0]  seg;
  } track_answer_t;

  logic [31:0]   trk_time [KEYS_DEF];
  logic [31:0]   trk_x    [KEYS_DEF];
  logic [31:0]   trk_y    [KEYS_DEF];
  logic [31:0]   trk_z    [KEYS_DEF];
  logic [6:0]    key_count;
  track_answer_t predicted_answers [$];
  int            mismatch_cnt = 0;
  int            pending_cnt = 0;

  assign mismatches  = mismatch_cnt;
  assign outstanding = pending_cnt;

  // start + floor(factor * (end - start) / 2^16)
  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint f);
    longint s;
    longint e;
    longint p;
    longint sum;
    s = $signed(a);
    e = $signed(b);
    p = f * (e - s);
    sum = s + (p >>> 16);
    return sum[31:0];
  endfunction

  function automatic track_answer_t key_answer(int k, logic [1:0] st);
    track_answer_t r;
    r.x = trk_x[k];
    r.y = trk_y[k];
    r.z = trk_z[k];
    r.status = st;
    r.seg = k[5:0];
    return r;
  endfunction

  function automatic track_answer_t sample_track(logic [31:0] qt);
    track_answer_t r;
    int n;
    int seg;
    bit hit;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] f;
    n = (key_count == 0) ? 1 : (key_count > KEYS_DEF) ? KEYS_DEF : int'(key_count);
    seg = 0;
    hit = 1'b0;
    if (n == 1) return key_answer(0, ST_INTERP);
    for (int i = 0; i + 1 < n; i++) begin
      if (!hit && qt < trk_time[i+1]) begin
        seg = i;
        hit = 1'b1;
      end
    end
    if (!hit) return key_answer(n - 1, ST_CLAMP);
    // unordered pair or query before the first key
    if (qt < trk_time[seg]) return key_answer(seg, ST_CLAMP);
    num = {16'd0, qt - trk_time[seg], 16'd0};
    den = {32'd0, trk_time[seg+1] - trk_time[seg]};
    f = num / den;
    r.x = blend(trk_x[seg], trk_x[seg+1], longint'(f));
    r.y = blend(trk_y[seg], trk_y[seg+1], longint'(f));
    r.z = blend(trk_z[seg], trk_z[seg+1], longint'(f));
    r.status = ST_INTERP;
    r.seg = seg[5:0];
    return r;
  endfunction

  task automatic enqueue_answer(track_answer_t a);
    predicted_answers = {predicted_answers, a};
    pending_cnt = predicted_answers.size();
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Everything settles by the falling edge; these values are what the block
  // sees at the following rising edge.
  always @(negedge clk) begin
    track_answer_t want;
    if (!rst_n) begin
      key_count = 7'd1;
      predicted_answers.delete();
      pending_cnt = 0;
    end else begin
      if (out_valid) begin
        if (predicted_answers.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result, expected none, actual %h %h %h %0d %0d",
                   $time, out_x, out_y, out_z, out_status, out_segment);
        end else begin
          want = predicted_answers.pop_front();
          pending_cnt = predicted_answers.size();
          check_field("x", want.x, out_x);
          check_field("y", want.y, out_y);
          check_field("z", want.z, out_z);
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("segment", 32'(want.seg), 32'(out_segment));
        end
      end
      if (cfg_we) key_count = cfg_wdata;
      if (start && !busy) begin
        if (in_action == ACT_LOAD) begin
          trk_time[in_key_index] = in_key_time;
          trk_x[in_key_index] = in_key_x;
          trk_y[in_key_index] = in_key_y;
          trk_z[in_key_index] = in_key_z;
          want = '0;
          want.status = ST_LOAD;
          enqueue_answer(want);
        end else begin
          enqueue_answer(sample_track(in_query_time));
        end
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for the keyframe vector interpolator
// Loads key tracks and queries them: a short directed part with extreme
// values, clamping and unordered keys, then random tracks of many sizes and
// key counts with queries spread over and around the key times. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import kvi_pkg::*;

  localparam int LIMIT = 1_000_000;
  localparam int ITEMS = 1700;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               in_action = ACT_LOAD;
  logic [5:0]         in_key_index = '0;
  logic [31:0]        in_key_time = '0;
  logic signed [31:0] in_key_x = '0;
  logic signed [31:0] in_key_y = '0;
  logic signed [31:0] in_key_z = '0;
  logic [31:0]        in_query_time = '0;
  logic               cfg_we = 1'b0;
  logic [6:0]         cfg_wdata = '0;
  logic               busy;
  logic               out_valid;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [1:0]         out_status;
  logic [5:0]         out_segment;

  int          fails;
  int          pending;
  int          idle_pct = 0;
  int          sent = 0;
  int          cycles = 0;
  logic [31:0] slot_time [KEYS_DEF];

  keyframe_vector_interpolator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_key_index(in_key_index), .in_key_time(in_key_time),
    .in_key_x(in_key_x), .in_key_y(in_key_y), .in_key_z(in_key_z),
    .in_query_time(in_query_time), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_status(out_status), .out_segment(out_segment)
  );

  kvi_track_checker track_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_key_index(in_key_index), .in_key_time(in_key_time),
    .in_key_x(in_key_x), .in_key_y(in_key_y), .in_key_z(in_key_z),
    .in_query_time(in_query_time), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_status(out_status), .out_segment(out_segment),
    .mismatches(fails), .outstanding(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Leaves start high after acceptance; the caller's next step drives a new item or lowers it.
  task automatic send_item(logic act, logic [5:0] idx, logic [31:0] t,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [31:0] qt);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_key_index <= idx;
    in_key_time <= t;
    in_key_x <= x;
    in_key_y <= y;
    in_key_z <= z;
    in_query_time <= qt;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    sent++;
  endtask

  task automatic load_key(int k, logic [31:0] t, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z);
    slot_time[k] = t;
    send_item(ACT_LOAD, k[5:0], t, x, y, z, $urandom());
  endtask

  task automatic query(logic [31:0] qt);
    send_item(ACT_QUERY, 6'($urandom()), $urandom(), $urandom(), $urandom(),
              $urandom(), qt);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_count(logic [6:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= 7'($urandom());
  endtask

  function automatic logic [31:0] pick_time(int n);
    int i;
    logic [31:0] lo;
    logic [31:0] hi;
    i = (n > 1) ? $urandom_range(n - 2) : 0;
    lo = slot_time[i];
    hi = slot_time[i+1];
    if (n == 1) return rnd_val();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
      2: return slot_time[$urandom_range(n - 1)];
      3: return slot_time[$urandom_range(n - 1)] - 32'd1;
      default: return (hi > lo) ? lo + $urandom_range(hi - lo - 1) : lo;
    endcase
  endfunction

  initial begin
    int          phase_no;
    int          n;
    int          nq;
    logic [6:0]  cv;
    bit          shuffled;
    longint      t;
    longint      base;
    longint      room;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single key track, reset count and a count of zero
    idle_pct = 6;
    load_key(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    query(32'h0);
    query(32'hFFFF_FFFF);
    settle();
    set_count(7'd0);
    query(32'h1234_5678);
    load_key(1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    load_key(2, 32'h0003_0000, 32'h0, 32'h0, 32'h1);
    load_key(3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    settle();
    set_count(7'd4);
    query(32'h0);
    query(32'h0001_0000);
    query(32'h0002_0000);
    query(32'h0002_FFFF);
    query(32'h0003_0000);
    query(32'hFFFF_FFFE);
    query(32'hFFFF_FFFF);
    // first pair out of order
    load_key(1, 32'h0000_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    query(32'h0000_4000);
    query(32'h0000_C000);

    phase_no = 0;
    while (sent < ITEMS) begin
      idle_pct = (sent < ITEMS / 3) ? 6 : (sent < 2 * ITEMS / 3) ? 69 : 0;
      case (phase_no)
        0: cv = 7'd127;
        1: cv = 7'd2;
        2: cv = 7'd64;
        3: cv = 7'd1;
        4: cv = 7'd0;
        default: cv = ($urandom_range(5) == 0) ? 7'($urandom_range(127))
                                               : 7'($urandom_range(12, 2));
      endcase
      n = (cv == 0) ? 1 : (cv > KEYS_DEF) ? KEYS_DEF : int'(cv);
      settle();
      set_count(cv);
      shuffled = ($urandom_range(4) == 0);
      base = longint'($urandom() >> $urandom_range(31));
      room = (64'hFFFF_FFFF - base) / n;
      if ($urandom_range(1) && room > 4096) room = $urandom_range(4096, 1);
      t = base;
      for (int k = 0; k < n; k++) begin
        load_key(k, shuffled ? $urandom() : t[31:0], rnd_val(), rnd_val(), rnd_val());
        t = t + $urandom_range(room[31:0]);
      end
      nq = $urandom_range(40, 15);
      for (int j = 0; j < nq; j++) begin
        if ($urandom_range(9) == 0)
          load_key($urandom_range(KEYS_DEF - 1), $urandom(), rnd_val(), rnd_val(),
                   rnd_val());
        else
          query(pick_time(n));
      end
      phase_no++;
    end

    settle();
    repeat (100) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== keyframe_vector_interpolator.f =====
rtl/core/kvi_pkg.sv
rtl/core/kvi_frac_div.sv
rtl/core/keyframe_vector_interpolator.sv
verif/kvi_track_checker.sv
verif/tb.sv
